/* rtl/uice_pkg.sv */
// shared types and constants of the universal integer code encoder
package uice_pkg;

   // value bits taken from the request, higher bits are ignored
   localparam int ValueBits = 32;
   localparam logic [31:0] ValueMask = 32'((64'd1 << ValueBits) - 64'd1);

   // longest value that unary can send in one codeword
   localparam int UnaryMax = 64;

   typedef enum logic [1:0] {
      KIND_UNARY = 2'd0,
      KIND_GAMMA = 2'd1,
      KIND_DELTA = 2'd2
   } kind_type;

   // bit length of the value and bit length of that length
   typedef struct packed {
      logic [5:0] val_len;
      logic [2:0] len_len;
   } len_info_type;

endpackage

/* rtl/universal_integer_code_encoder_top.sv */
// universal integer code encoder: unary, gamma and delta codewords
//
// A request is taken at a rising edge with start high and busy low; it
// carries req_kind (0 unary, 1 gamma, 2 delta) and req_value, of which the
// low ValueBits bits are used. Each request gives one response: the
// right-aligned codeword rsp_code (first-sent bit highest), its length
// rsp_code_length and rsp_error, shown for one cycle with rsp_strobe high.
// Zero values, unary values above 64 and the unused kind raise rsp_error
// with code and length zero.
// The request is registered at the accepting edge, the codeword is formed
// by priority encoders and barrel shifts in the next cycle and registered
// in the output registers that drive rsp_strobe.
// Throughput: one request every cycle, set by the single pass through the
// length encoders and shifters between the two register stages.
// busy is high only while reset is held; a synchronous reset drops any
// request in flight and clears the strobe. The receiver cannot stall, so
// responses never wait.
module universal_integer_code_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_value,
   output logic        rsp_strobe,
   output logic [63:0] rsp_code,
   output logic [6:0]  rsp_code_length,
   output logic        rsp_error
);
   import uice_pkg::*;

   logic         req_valid_ff, req_valid_in;
   logic [1:0]   kind_ff;
   logic [31:0]  value_ff;
   logic         rsp_strobe_ff;
   logic [63:0]  code_ff;
   logic [6:0]   code_length_ff;
   logic         error_ff;

   len_info_type info;
   logic [63:0]  code_c;
   logic [6:0]   code_length_c;
   logic         error_c;

   assign busy         = reset;
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         kind_ff  <= req_kind;
         value_ff <= req_value & ValueMask;
      end
      if (req_valid_ff) begin
         code_ff        <= code_c;
         code_length_ff <= code_length_c;
         error_ff       <= error_c;
      end
   end

   uice_lenc u_lenc (
      .value (value_ff),
      .info  (info)
   );

   uice_form u_form (
      .kind        (kind_ff),
      .value       (value_ff),
      .info        (info),
      .code        (code_c),
      .code_length (code_length_c),
      .error       (error_c)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_code        = code_ff;
   assign rsp_code_length = code_length_ff;
   assign rsp_error       = error_ff;

endmodule

/* rtl/uice_lenc.sv */
// priority encoders giving the bit length of the value and of that length
module uice_lenc (
   input  logic [31:0]           value,
   output uice_pkg::len_info_type info
);
   import uice_pkg::*;

   function automatic logic [5:0] bit_length(input logic [31:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 6'(i + 1);
         end
      end
      return n;
   endfunction

   logic [5:0] val_len;
   logic [5:0] len_of_len;

   assign val_len    = bit_length(value);
   assign len_of_len = bit_length({26'b0, val_len});

   assign info.val_len = val_len;
   assign info.len_len = len_of_len[2:0];

endmodule

/* rtl/uice_form.sv */
// codeword assembly for unary, gamma and delta codes
module uice_form (
   input  logic [1:0]             kind,
   input  logic [31:0]            value,
   input  uice_pkg::len_info_type info,
   output logic [63:0]            code,
   output logic [6:0]             code_length,
   output logic                   error
);
   import uice_pkg::*;

   logic [63:0] v64;
   logic [5:0]  lm1;
   logic [63:0] top_bit;
   logic [63:0] low_mask;
   logic [63:0] gamma_code;
   logic [2:0]  mm1;
   logic [10:0] len_mask;
   logic [10:0] len_gamma;
   logic [63:0] delta_code;
   logic [6:0]  unary_m1;
   logic [63:0] unary_code;
   logic [6:0]  gamma_len;
   logic [6:0]  delta_len;
   logic [63:0] code_sel;
   logic [6:0]  len_sel;
   logic        err;

   always_comb begin
      v64      = {32'b0, value};
      lm1      = info.val_len - 6'd1;
      top_bit  = 64'd1 << lm1;
      low_mask = top_bit - 64'd1;
      // l-1 ones, a zero, then the bits below the leading one
      gamma_code = (low_mask << info.val_len) | (v64 & low_mask);

      // gamma code of the length itself, at most 11 bits
      mm1        = info.len_len - 3'd1;
      len_mask   = (11'd1 << mm1) - 11'd1;
      len_gamma  = (len_mask << info.len_len) | ({5'b0, info.val_len} & len_mask);
      delta_code = ({53'b0, len_gamma} << lm1) | (v64 & low_mask);

      unary_m1   = value[6:0] - 7'd1;
      unary_code = ((64'd1 << unary_m1[5:0]) - 64'd1) << 1;

      gamma_len = {info.val_len, 1'b0} - 7'd1;
      delta_len = {3'b0, info.len_len, 1'b0} + {1'b0, info.val_len} - 7'd2;

      err      = 1'b0;
      code_sel = '0;
      len_sel  = '0;
      case (kind_type'(kind))
         KIND_UNARY: begin
            if (value > 32'(UnaryMax)) begin
               err = 1'b1;
            end
            code_sel = unary_code;
            len_sel  = value[6:0];
         end
         KIND_GAMMA: begin
            code_sel = gamma_code;
            len_sel  = gamma_len;
         end
         KIND_DELTA: begin
            code_sel = delta_code;
            len_sel  = delta_len;
         end
         default: begin
            err = 1'b1;
         end
      endcase
      if (value == '0) begin
         err = 1'b1;
      end

      code        = err ? '0 : code_sel;
      code_length = err ? '0 : len_sel;
      error       = err;
   end

endmodule

/* rtl/uice_checker.sv */
// port-level checks of the encoder, bound to the top level
module uice_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [63:0] rsp_code,
   input logic [6:0]  rsp_code_length,
   input logic        rsp_error
);

   // every request gives a response
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_strobe)
      else $error("request without response");

   // no response without a request
   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without request");

   // an error carries an empty codeword
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_error |-> rsp_code == 64'd0 && rsp_code_length == 7'd0)
      else $error("error with non-empty codeword");

   // a good codeword has a length in range and nothing above it
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_error |-> rsp_code_length != 7'd0 && rsp_code_length <= 7'd64)
      else $error("codeword length out of range");

   a_code_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_error |-> (rsp_code >> rsp_code_length) == 64'd0)
      else $error("codeword bits above its length");

endmodule

bind universal_integer_code_encoder_top uice_checker u_uice_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_code        (rsp_code),
   .rsp_code_length (rsp_code_length),
   .rsp_error       (rsp_error)
);
